@@ rtl/cfts_pkg.sv @@
// Shared types, codes and constants for the CAN frame traffic statistics block.
`timescale 1ns / 1ps
`default_nettype none
package cfts_pkg;

  localparam int STD_ID_SLOTS_DEF = 2048;
  localparam int NODE_SLOTS_DEF   = 64;

  localparam logic [15:0] WINDOW_LENGTH_RESET = 16'd1000;
  localparam logic [31:0] MS_PER_SECOND       = 32'd1000;
  localparam logic [31:0] ALL_ONES            = 32'hFFFF_FFFF;

  // Request modes
  localparam logic [2:0] MODE_FRAME   = 3'd0;
  localparam logic [2:0] MODE_POLL    = 3'd1;
  localparam logic [2:0] MODE_RD_ID   = 3'd2;
  localparam logic [2:0] MODE_RD_NODE = 3'd3;
  localparam logic [2:0] MODE_RD_SUM  = 3'd4;

  // Summary read indexes
  localparam logic [28:0] SUM_TOTAL    = 29'd0;
  localparam logic [28:0] SUM_STANDARD = 29'd1;
  localparam logic [28:0] SUM_EXTENDED = 29'd2;
  localparam logic [28:0] SUM_REMOTE   = 29'd3;
  localparam logic [28:0] SUM_MIN_GAP  = 29'd4;
  localparam logic [28:0] SUM_MAX_GAP  = 29'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_DIVIDE,
    ST_DONE
  } cfts_state_t;

  typedef struct packed {
    logic [28:0] masked_id;
    logic [6:0]  length_bytes;
    logic [31:0] gap_ms;
    logic        gap_valid;
    logic [5:0]  node_number;
    logic [4:0]  command_number;
    logic        window_closed;
    logic [31:0] window_frames;
    logic [31:0] window_span_ms;
    logic [31:0] frames_per_second;
    logic [31:0] read_value;
  } cfts_result_t;

  // CAN FD length code to byte count
  function automatic logic [6:0] dlc_to_bytes(input logic [3:0] code);
    logic [6:0] n;
    case (code)
      4'd9:    n = 7'd12;
      4'd10:   n = 7'd16;
      4'd11:   n = 7'd20;
      4'd12:   n = 7'd24;
      4'd13:   n = 7'd32;
      4'd14:   n = 7'd48;
      4'd15:   n = 7'd64;
      default: n = {3'b000, code};
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

@@ rtl/cfts_item_if.sv @@
// Request channel carrying one frame, poll or read request.
`timescale 1ns / 1ps
`default_nettype none
interface cfts_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] now_ms;
  logic [28:0] identifier;
  logic        is_extended;
  logic        is_remote;
  logic [3:0]  dlc_code;

  modport source (output valid, mode, now_ms, identifier, is_extended, is_remote, dlc_code,
                  input ready);
  modport sink   (input valid, mode, now_ms, identifier, is_extended, is_remote, dlc_code,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/cfts_result_if.sv @@
// Result channel carrying one statistics result per request.
`timescale 1ns / 1ps
`default_nettype none
interface cfts_result_if;
  logic        valid;
  logic        ready;
  logic [28:0] masked_id;
  logic [6:0]  length_bytes;
  logic [31:0] gap_ms;
  logic        gap_valid;
  logic [5:0]  node_number;
  logic [4:0]  command_number;
  logic        window_closed;
  logic [31:0] window_frames;
  logic [31:0] window_span_ms;
  logic [31:0] frames_per_second;
  logic [31:0] read_value;

  modport source (output valid, masked_id, length_bytes, gap_ms, gap_valid, node_number,
                  command_number, window_closed, window_frames, window_span_ms,
                  frames_per_second, read_value, input ready);
  modport sink   (input valid, masked_id, length_bytes, gap_ms, gap_valid, node_number,
                  command_number, window_closed, window_frames, window_span_ms,
                  frames_per_second, read_value, output ready);
endinterface
`default_nettype wire

@@ rtl/cfts_ram.sv @@
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module cfts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/can_frame_traffic_statistics.sv @@
// Top level of the CAN frame traffic statistics monitor.
// Every request (frame, rate-window poll, or read) returns exactly one result. After reset
// the block sweeps both histogram RAMs to zero, one entry a cycle, and holds item.ready low
// meanwhile; wr_en writes are taken at any time. Frames, reads and polls that do not close
// a window are fetched from the histogram RAMs, updated and then output. A poll that closes
// a window also runs a radix-2 restoring divider, one quotient bit a cycle, before output.
// One request is in flight at a time; the output register lets the next request enter
// while a finished result still waits for result.ready, and a second finished result waits
// in the output step until the first one is taken.
`timescale 1ns / 1ps
`default_nettype none
module can_frame_traffic_statistics import cfts_pkg::*; #(
  parameter int STD_ID_SLOTS = STD_ID_SLOTS_DEF,
  parameter int NODE_SLOTS   = NODE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [15:0] wr_data,
  cfts_item_if.sink   item,
  cfts_result_if.source result
);

  localparam int ID_AW   = $clog2(STD_ID_SLOTS);
  localparam int NODE_AW = $clog2(NODE_SLOTS);
  localparam logic [ID_AW-1:0] CLR_LAST = ID_AW'(STD_ID_SLOTS - 1);

  cfts_state_t state, state_next;

  // Configuration and statistics
  logic [15:0] window_length;
  logic [31:0] previous_frame_tick;
  logic [31:0] smallest_gap;
  logic [31:0] largest_gap;
  logic [31:0] frames_total;
  logic [31:0] frames_standard;
  logic [31:0] frames_extended;
  logic [31:0] frames_remote;
  logic [31:0] window_start_tick;
  logic [31:0] window_start_total;

  // Latched request
  logic [2:0]  mode_r;
  logic [31:0] now_r;
  logic [28:0] ident_r;
  logic        ext_r;
  logic        rtr_r;
  logic [3:0]  dlc_r;

  // Divider
  logic [31:0] dq;
  logic [31:0] drem;
  logic [31:0] ddiv;
  logic [4:0]  div_cnt;
  logic [32:0] rem_sh;
  logic        sub_ok;
  logic [31:0] dq_step;
  logic [31:0] drem_step;

  // Result staging and output register
  cfts_result_t res;
  cfts_result_t res_exec;
  cfts_result_t out_q;
  logic         out_valid;

  logic [ID_AW-1:0] clr_idx;

  // RAM ports
  logic               id_we;
  logic [ID_AW-1:0]   id_waddr;
  logic [31:0]        id_wdata;
  logic [ID_AW-1:0]   id_raddr;
  logic [31:0]        id_rdata;
  logic               node_we;
  logic [NODE_AW-1:0] node_waddr;
  logic [31:0]        node_wdata;
  logic [NODE_AW-1:0] node_raddr;
  logic [31:0]        node_rdata;

  // Frame and poll arithmetic
  logic [31:0] gap;
  logic [31:0] span;
  logic        closed;
  logic [31:0] count;
  logic [31:0] scaled;
  logic        std_update;
  logic        clearing;
  logic        out_free;

  assign gap        = now_r - previous_frame_tick;
  assign span       = now_r - window_start_tick;
  assign closed     = span >= {16'd0, window_length};
  assign count      = frames_total - window_start_total;
  assign scaled     = 32'(count * MS_PER_SECOND);
  assign std_update = (state == ST_EXEC) && (mode_r == MODE_FRAME) && !ext_r;
  assign clearing   = (state == ST_CLEAR);
  assign out_free   = !out_valid || result.ready;

  // One restoring divide step
  assign rem_sh    = {drem, dq[31]};
  assign sub_ok    = rem_sh >= {1'b0, ddiv};
  assign drem_step = sub_ok ? 32'(rem_sh - {1'b0, ddiv}) : rem_sh[31:0];
  assign dq_step   = {dq[30:0], sub_ok};

  cfts_ram #(.WIDTH(32), .DEPTH(STD_ID_SLOTS)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (id_waddr),
    .wdata (id_wdata),
    .raddr (id_raddr),
    .rdata (id_rdata)
  );

  cfts_ram #(.WIDTH(32), .DEPTH(NODE_SLOTS)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_idx == CLR_LAST) state_next = ST_IDLE;
      ST_IDLE:   if (item.valid) state_next = ST_FETCH;
      ST_FETCH:  state_next = ST_EXEC;
      ST_EXEC: begin
        if ((mode_r == MODE_POLL) && closed) state_next = ST_DIVIDE;
        else state_next = ST_DONE;
      end
      ST_DIVIDE: if (div_cnt == 5'd31) state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  // Handshake and RAM control
  always_comb begin
    item.ready = (state == ST_IDLE);
    id_raddr   = ident_r[ID_AW-1:0];
    node_raddr = (mode_r == MODE_FRAME) ? NODE_AW'(ident_r[10:5]) : ident_r[NODE_AW-1:0];
    id_we      = clearing || std_update;
    node_we    = clearing || std_update;
    id_waddr   = clearing ? clr_idx : id_raddr;
    node_waddr = clearing ? clr_idx[NODE_AW-1:0] : node_raddr;
    id_wdata   = clearing ? 32'd0 : id_rdata + 32'd1;
    node_wdata = clearing ? 32'd0 : node_rdata + 32'd1;
  end

  // Output channel
  assign result.valid             = out_valid;
  assign result.masked_id         = out_q.masked_id;
  assign result.length_bytes      = out_q.length_bytes;
  assign result.gap_ms            = out_q.gap_ms;
  assign result.gap_valid         = out_q.gap_valid;
  assign result.node_number       = out_q.node_number;
  assign result.command_number    = out_q.command_number;
  assign result.window_closed     = out_q.window_closed;
  assign result.window_frames     = out_q.window_frames;
  assign result.window_span_ms    = out_q.window_span_ms;
  assign result.frames_per_second = out_q.frames_per_second;
  assign result.read_value        = out_q.read_value;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_LENGTH_RESET;
    end else if (wr_en) begin
      window_length <= wr_data;
    end
  end

  // Sequencer state, clear sweep and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_idx <= clr_idx + ID_AW'(1);
      end
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      out_q <= res;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && item.valid) begin
      mode_r  <= item.mode;
      now_r   <= item.now_ms;
      ident_r <= item.identifier;
      ext_r   <= item.is_extended;
      rtr_r   <= item.is_remote;
      dlc_r   <= item.dlc_code;
    end
  end

  // Statistics update
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_frame_tick <= '0;
      smallest_gap        <= ALL_ONES;
      largest_gap         <= '0;
      frames_total        <= '0;
      frames_standard     <= '0;
      frames_extended     <= '0;
      frames_remote       <= '0;
      window_start_tick   <= '0;
      window_start_total  <= '0;
    end else if (state == ST_EXEC) begin
      if (mode_r == MODE_FRAME) begin
        if (previous_frame_tick != 32'd0) begin
          if (gap < smallest_gap) smallest_gap <= gap;
          if (gap > largest_gap) largest_gap <= gap;
        end
        previous_frame_tick <= now_r;
        frames_total        <= frames_total + 32'd1;
        if (rtr_r) frames_remote <= frames_remote + 32'd1;
        if (ext_r) frames_extended <= frames_extended + 32'd1;
        else frames_standard <= frames_standard + 32'd1;
      end else if ((mode_r == MODE_POLL) && closed) begin
        window_start_total <= frames_total;
        window_start_tick  <= now_r;
      end
    end
  end

  // Step counter for the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (state == ST_EXEC) begin
      div_cnt <= '0;
    end else if (state == ST_DIVIDE) begin
      div_cnt <= div_cnt + 5'd1;
    end
  end

  // Assemble the result fields of the fetched request
  always_comb begin
    res_exec = '0;
    case (mode_r)
      MODE_FRAME: begin
        res_exec.masked_id    = ext_r ? ident_r : {18'd0, ident_r[10:0]};
        res_exec.length_bytes = dlc_to_bytes(dlc_r);
        if (previous_frame_tick != 32'd0) begin
          res_exec.gap_ms    = gap;
          res_exec.gap_valid = 1'b1;
        end
        if (!ext_r) begin
          res_exec.node_number    = ident_r[10:5];
          res_exec.command_number = ident_r[4:0];
        end
      end
      MODE_POLL: begin
        if (closed) begin
          res_exec.window_closed  = 1'b1;
          res_exec.window_frames  = count;
          res_exec.window_span_ms = span;
        end
      end
      MODE_RD_ID: begin
        if (ident_r < 29'(STD_ID_SLOTS)) res_exec.read_value = id_rdata;
      end
      MODE_RD_NODE: begin
        if (ident_r < 29'(NODE_SLOTS)) res_exec.read_value = node_rdata;
      end
      MODE_RD_SUM: begin
        case (ident_r)
          SUM_TOTAL:    res_exec.read_value = frames_total;
          SUM_STANDARD: res_exec.read_value = frames_standard;
          SUM_EXTENDED: res_exec.read_value = frames_extended;
          SUM_REMOTE:   res_exec.read_value = frames_remote;
          SUM_MIN_GAP:  res_exec.read_value = smallest_gap;
          SUM_MAX_GAP:  res_exec.read_value = largest_gap;
          default:      res_exec.read_value = 32'd0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      res  <= res_exec;
      dq   <= scaled;
      drem <= '0;
      ddiv <= span;
    end else if (state == ST_DIVIDE) begin
      dq   <= dq_step;
      drem <= drem_step;
      if (div_cnt == 5'd31) begin
        res.frames_per_second <= (ddiv == 32'd0) ? ALL_ONES : dq_step;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/cfts_checker.sv @@
// Port-level checks for the CAN frame traffic statistics block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module cfts_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [6:0]  length_bytes,
  input wire logic        gap_valid,
  input wire logic [31:0] gap_ms,
  input wire logic        window_closed,
  input wire logic [31:0] read_value
);

  // Hold ready low through reset and the first cycle of the clear sweep
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("request taken during histogram clear");

  // Drop ready right after taking a request
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in flight");

  // Hold a stalled result
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

  // Keep closed-window poll results free of frame and read fields
  a_poll_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && window_closed) |->
      (!gap_valid && gap_ms == 32'd0 && read_value == 32'd0 && length_bytes == 7'd0))
    else $error("closed window result carries frame or read fields");

  // Keep a missing gap at zero
  a_gap_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !gap_valid) |-> (gap_ms == 32'd0))
    else $error("gap reported without a valid previous tick");

endmodule

bind can_frame_traffic_statistics cfts_checker u_cfts_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (item.valid),
  .in_ready      (item.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .length_bytes  (result.length_bytes),
  .gap_valid     (result.gap_valid),
  .gap_ms        (result.gap_ms),
  .window_closed (result.window_closed),
  .read_value    (result.read_value)
);
`default_nettype wire

@@ test/tb_can_frame_traffic_statistics.sv @@
// Testbench for the CAN frame traffic statistics block: random and directed requests.
`timescale 1ns / 1ps
module tb_can_frame_traffic_statistics;
  import cfts_pkg::*;

  localparam int PHASES           = 7;
  localparam int RANDOM_PER_PHASE = 285;
  localparam int SETTLE_CYCLES    = 48;
  localparam int STUCK_LIMIT      = 8000;

  // payload of one request as driven on the item channel
  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] now_ms;
    logic [28:0] identifier;
    logic        is_extended;
    logic        is_remote;
    logic [3:0]  dlc_code;
  } traffic_req_t;

  localparam logic [6:0] BYTES_PER_CODE [16] = '{
    7'd0, 7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7,
    7'd8, 7'd12, 7'd16, 7'd20, 7'd24, 7'd32, 7'd48, 7'd64
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        wr_en;
  logic [15:0] wr_data;

  cfts_item_if   req_ch ();
  cfts_result_if res_ch ();

  can_frame_traffic_statistics DUT (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .item    (req_ch),
    .result  (res_ch)
  );

  always #4 clk = ~clk;

  // traffic statistics as the block should hold them
  logic [15:0] win_len_ms;
  logic [31:0] last_frame_ms;
  logic [31:0] min_gap_ms;
  logic [31:0] max_gap_ms;
  logic [31:0] total_frames;
  logic [31:0] std_frames;
  logic [31:0] ext_frames;
  logic [31:0] remote_frames;
  logic [31:0] id_hits [STD_ID_SLOTS_DEF];
  logic [31:0] node_hits [NODE_SLOTS_DEF];
  logic [31:0] win_start_ms;
  logic [31:0] win_start_total;

  traffic_req_t req_backlog [$];
  cfts_result_t stats_expected [$];

  traffic_req_t seen_req;
  traffic_req_t next_req;
  cfts_result_t want;
  logic         req_taken;
  int           send_hold;
  int           recv_hold;
  int           stuck_cycles;
  int           error_count;
  bit           idling_on;
  logic [31:0]  clock_ms;

  // update the statistics for one accepted request and return its result
  function automatic cfts_result_t predict_stats(input traffic_req_t rq);
    cfts_result_t r;
    logic [28:0]  id;
    logic [31:0]  gap;
    logic [31:0]  span;
    logic [31:0]  count;
    logic [31:0]  scaled;
    logic [5:0]   node;
    r = '0;
    case (rq.mode)
      MODE_FRAME: begin
        id = rq.is_extended ? rq.identifier : {18'd0, rq.identifier[10:0]};
        r.masked_id = id;
        r.length_bytes = BYTES_PER_CODE[rq.dlc_code];
        // no gap until a nonzero previous tick exists
        if (last_frame_ms != 32'd0) begin
          gap = rq.now_ms - last_frame_ms;
          if (gap < min_gap_ms) min_gap_ms = gap;
          if (gap > max_gap_ms) max_gap_ms = gap;
          r.gap_ms = gap;
          r.gap_valid = 1'b1;
        end
        last_frame_ms = rq.now_ms;
        total_frames = total_frames + 32'd1;
        if (rq.is_remote) remote_frames = remote_frames + 32'd1;
        if (rq.is_extended) begin
          ext_frames = ext_frames + 32'd1;
        end else begin
          node = id[10:5];
          std_frames = std_frames + 32'd1;
          id_hits[id[10:0]] = id_hits[id[10:0]] + 32'd1;
          node_hits[node] = node_hits[node] + 32'd1;
          r.node_number = node;
          r.command_number = id[4:0];
        end
      end
      MODE_POLL: begin
        span = rq.now_ms - win_start_ms;
        if (span >= {16'd0, win_len_ms}) begin
          count = total_frames - win_start_total;
          scaled = count * MS_PER_SECOND;
          r.window_closed = 1'b1;
          r.window_frames = count;
          r.window_span_ms = span;
          r.frames_per_second = (span != 32'd0) ? scaled / span : ALL_ONES;
          win_start_total = total_frames;
          win_start_ms = rq.now_ms;
        end
      end
      MODE_RD_ID:
        r.read_value = (rq.identifier < STD_ID_SLOTS_DEF) ? id_hits[rq.identifier[10:0]] : '0;
      MODE_RD_NODE:
        r.read_value = (rq.identifier < NODE_SLOTS_DEF) ? node_hits[rq.identifier[5:0]] : '0;
      MODE_RD_SUM: begin
        case (rq.identifier)
          SUM_TOTAL:    r.read_value = total_frames;
          SUM_STANDARD: r.read_value = std_frames;
          SUM_EXTENDED: r.read_value = ext_frames;
          SUM_REMOTE:   r.read_value = remote_frames;
          SUM_MIN_GAP:  r.read_value = min_gap_ms;
          SUM_MAX_GAP:  r.read_value = max_gap_ms;
          default:      r.read_value = '0;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] exp);
    if (got !== exp) flag_error($sformatf("%s got 0x%08h, expected 0x%08h", name, got, exp));
  endtask

  task automatic push_req(input logic [2:0] m, input logic [31:0] t, input logic [28:0] id,
                          input logic ext, input logic rtr, input logic [3:0] dlc);
    req_backlog.push_back('{mode: m, now_ms: t, identifier: id, is_extended: ext,
                            is_remote: rtr, dlc_code: dlc});
  endtask

  // wait until every queued request has been sent and answered
  task automatic drain_requests();
    do @(posedge clk);
    while (req_backlog.size() != 0 || req_ch.valid || stats_expected.size() != 0);
  endtask

  // request driver: hold each request until accepted, idle in bursts
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (send_hold > 0) begin
        send_hold <= send_hold - 1;
        req_ch.valid <= 1'b0;
      end else if (req_backlog.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        send_hold <= $urandom_range(0, 16);
        req_ch.valid <= 1'b0;
      end else begin
        next_req = req_backlog.pop_front();
        req_ch.valid       <= 1'b1;
        req_ch.mode        <= next_req.mode;
        req_ch.now_ms      <= next_req.now_ms;
        req_ch.identifier  <= next_req.identifier;
        req_ch.is_extended <= next_req.is_extended;
        req_ch.is_remote   <= next_req.is_remote;
        req_ch.dlc_code    <= next_req.dlc_code;
      end
    end
  end

  // result sink: stall in bursts
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      res_ch.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      recv_hold <= $urandom_range(0, 16);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // predict on each accepted request; watch for a stuck block
  always @(posedge clk) begin
    req_taken <= !rst && req_ch.valid && req_ch.ready;
    if (!rst && req_ch.valid && req_ch.ready) begin
      seen_req = '{mode: req_ch.mode, now_ms: req_ch.now_ms, identifier: req_ch.identifier,
                   is_extended: req_ch.is_extended, is_remote: req_ch.is_remote,
                   dlc_code: req_ch.dlc_code};
      stats_expected.push_back(predict_stats(seen_req));
    end
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result monitor: compare against the oldest expectation
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (stats_expected.size() == 0) begin
        flag_error("result with no request waiting");
      end else begin
        want = stats_expected.pop_front();
        compare_field("masked_id", 32'(res_ch.masked_id), 32'(want.masked_id));
        compare_field("length_bytes", 32'(res_ch.length_bytes), 32'(want.length_bytes));
        compare_field("gap_ms", res_ch.gap_ms, want.gap_ms);
        compare_field("gap_valid", 32'(res_ch.gap_valid), 32'(want.gap_valid));
        compare_field("node_number", 32'(res_ch.node_number), 32'(want.node_number));
        compare_field("command_number", 32'(res_ch.command_number),
                      32'(want.command_number));
        compare_field("window_closed", 32'(res_ch.window_closed), 32'(want.window_closed));
        compare_field("window_frames", res_ch.window_frames, want.window_frames);
        compare_field("window_span_ms", res_ch.window_span_ms, want.window_span_ms);
        compare_field("frames_per_second", res_ch.frames_per_second,
                      want.frames_per_second);
        compare_field("read_value", res_ch.read_value, want.read_value);
      end
    end
  end

  initial begin
    traffic_req_t rq;
    int unsigned  pick;
    logic [10:0]  hot_ids [8];
    logic [15:0]  window_plan [PHASES];

    rst = 1'b1;
    wr_en = 1'b0;
    wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_FRAME;
    req_ch.now_ms = '0;
    req_ch.identifier = '0;
    req_ch.is_extended = 1'b0;
    req_ch.is_remote = 1'b0;
    req_ch.dlc_code = '0;
    res_ch.ready = 1'b0;
    req_taken = 1'b0;
    send_hold = 0;
    recv_hold = 0;
    stuck_cycles = 0;
    error_count = 0;
    idling_on = 1'b1;
    clock_ms = '0;

    // statistics after reset
    win_len_ms = WINDOW_LENGTH_RESET;
    last_frame_ms = '0;
    min_gap_ms = ALL_ONES;
    max_gap_ms = '0;
    total_frames = '0;
    std_frames = '0;
    ext_frames = '0;
    remote_frames = '0;
    win_start_ms = '0;
    win_start_total = '0;
    foreach (id_hits[i]) id_hits[i] = '0;
    foreach (node_hits[i]) node_hits[i] = '0;

    foreach (hot_ids[i]) hot_ids[i] = 11'($urandom());
    window_plan = '{WINDOW_LENGTH_RESET, 16'd1, 16'hFFFF, 16'd0,
                    16'($urandom_range(2, 65534)), 16'd250, WINDOW_LENGTH_RESET};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      // change the window length only while the block is idle
      if (p > 0) begin
        drain_requests();
        repeat (SETTLE_CYCLES) @(negedge clk);
        wr_en <= 1'b1;
        wr_data <= window_plan[p];
        @(negedge clk);
        wr_en <= 1'b0;
        win_len_ms = window_plan[p];
      end
      if (p == PHASES - 1) idling_on = 1'b0;

      if (p == 0) begin
        // extremes, gap start-up, wrap, window close and out-of-range reads
        push_req(MODE_RD_SUM, 32'd0, SUM_MIN_GAP, 1'b0, 1'b0, 4'd0);
        push_req(MODE_POLL, 32'd0, '0, 1'b0, 1'b0, 4'd0);
        push_req(MODE_FRAME, 32'd0, 29'h1FFF_FFFF, 1'b0, 1'b1, 4'd15);
        push_req(MODE_FRAME, 32'd5, 29'h7E0, 1'b0, 1'b0, 4'd0);
        push_req(MODE_FRAME, 32'd10, 29'h1FFF_FFFF, 1'b1, 1'b1, 4'd9);
        push_req(MODE_FRAME, ALL_ONES, '0, 1'b1, 1'b0, 4'd8);
        push_req(MODE_FRAME, 32'd3, 29'h01F, 1'b0, 1'b0, 4'd12);
        push_req(MODE_FRAME, 32'd1003, 29'h7FF, 1'b0, 1'b0, 4'd13);
        push_req(MODE_POLL, 32'd1003, '0, 1'b0, 1'b0, 4'd0);
        push_req(MODE_POLL, 32'd1004, '0, 1'b0, 1'b0, 4'd0);
        push_req(MODE_RD_ID, 32'd1004, 29'h7FF, 1'b0, 1'b0, 4'd0);
        push_req(MODE_RD_ID, 32'd1004, 29'(STD_ID_SLOTS_DEF), 1'b0, 1'b0, 4'd0);
        push_req(MODE_RD_ID, 32'd1004, 29'h1FFF_FFFF, 1'b0, 1'b0, 4'd0);
        push_req(MODE_RD_NODE, 32'd1004, 29'd63, 1'b0, 1'b0, 4'd0);
        push_req(MODE_RD_NODE, 32'd1004, 29'(NODE_SLOTS_DEF), 1'b0, 1'b0, 4'd0);
        for (int k = SUM_TOTAL; k <= SUM_MAX_GAP + 1; k++)
          push_req(MODE_RD_SUM, 32'd1004, 29'(k), 1'b0, 1'b0, 4'd0);
        push_req(MODE_RD_SUM, 32'd1004, 29'h1FFF_FFFF, 1'b0, 1'b0, 4'd0);
        for (int k = 1; k <= 3; k++)
          push_req(3'(MODE_RD_SUM + k), ALL_ONES, 29'h1FFF_FFFF, 1'b1, 1'b1, 4'd15);
        clock_ms = 32'd1004;
      end

      // zero window length: two polls at one tick close a window of zero span
      if (win_len_ms == 16'd0) begin
        push_req(MODE_POLL, clock_ms, '0, 1'b0, 1'b0, 4'd0);
        push_req(MODE_POLL, clock_ms, '0, 1'b0, 1'b0, 4'd0);
      end

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // advance the bus clock, mostly in small steps
        pick = $urandom_range(0, 99);
        if (pick < 70)      clock_ms = clock_ms + $urandom_range(0, 40);
        else if (pick < 90) clock_ms = clock_ms + $urandom_range(0, 2000);
        else if (pick < 97) clock_ms = clock_ms + $urandom_range(0, 80000);
        else                clock_ms = ($urandom_range(0, 3) == 0) ? '0 : $urandom();

        rq.now_ms = clock_ms;
        rq.identifier = 29'($urandom());
        rq.is_extended = ($urandom_range(0, 3) == 0);
        rq.is_remote = ($urandom_range(0, 4) == 0);
        rq.dlc_code = 4'($urandom());

        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          rq.mode = MODE_FRAME;
          if (!rq.is_extended && $urandom_range(0, 1) == 0)
            rq.identifier[10:0] = hot_ids[$urandom_range(0, 7)];
        end else if (pick < 65) begin
          rq.mode = MODE_POLL;
        end else if (pick < 77) begin
          rq.mode = MODE_RD_ID;
          pick = $urandom_range(0, 99);
          if (pick < 70)      rq.identifier = {18'd0, hot_ids[$urandom_range(0, 7)]};
          else if (pick < 85) rq.identifier = {18'd0, 11'($urandom())};
        end else if (pick < 85) begin
          rq.mode = MODE_RD_NODE;
          if ($urandom_range(0, 9) < 8) rq.identifier = {23'd0, 6'($urandom())};
        end else if (pick < 95) begin
          rq.mode = MODE_RD_SUM;
          if ($urandom_range(0, 99) < 85) rq.identifier = 29'($urandom_range(0, 5));
        end else begin
          rq.mode = 3'(MODE_RD_SUM + $urandom_range(1, 3));
        end
        req_backlog.push_back(rq);
      end
    end

    drain_requests();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (stats_expected.size() != 0)
      flag_error($sformatf("%0d results never arrived", stats_expected.size()));
    if (error_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ can_frame_traffic_statistics.f @@
rtl/cfts_pkg.sv
rtl/cfts_item_if.sv
rtl/cfts_result_if.sv
rtl/cfts_ram.sv
rtl/can_frame_traffic_statistics.sv
rtl/cfts_checker.sv
test/tb_can_frame_traffic_statistics.sv
